>>> hw/rtl/dspm_pkg.sv
// shared types and constants for the dot-star pattern matcher
package dspm_pkg;

  localparam int unsigned PAT_BYTES = 32;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_WORD_0 = 3'd0,
    CFG_PATTERN_WORD_1 = 3'd1,
    CFG_PATTERN_WORD_2 = 3'd2,
    CFG_PATTERN_WORD_3 = 3'd3,
    CFG_PATTERN_LENGTH = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_APPLY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_start;
    logic       empty_text;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic whole_match;
    logic end_of_text;
  } out_word_t;

  // wave handed from one cell to the next
  typedef struct packed {
    logic token;
    logic old_bit;
    logic new_bit;
    logic new_bit2;
  } wave_t;

  typedef struct packed {
    logic       clear;
    logic       load_empty;
    logic [7:0] text_byte;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/dspm_cell.sv
// one match cell: holds one row bit and updates it when the wave passes
module dspm_cell
  import dspm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] p_i,
  input  logic [7:0] q_i,
  input  logic       q_valid_i,
  input  logic       in_range_i,
  input  logic       not_last_i,
  input  wave_t      wave_i,
  output wave_t      wave_o,
  output logic       bit_o
);

  logic  bit_q, bit_d;
  logic  new_bit;
  logic  q_hit;
  wave_t wave_q, wave_d;

  assign q_hit = (q_i == ctrl_i.text_byte) || (q_i == CH_DOT);

  always_comb begin
    new_bit = 1'b0;
    if (!in_range_i) begin
      new_bit = 1'b0;
    end else if (ctrl_i.load_empty) begin
      new_bit = (p_i == CH_STAR) && q_valid_i && wave_i.new_bit2;
    end else if (p_i == CH_DOT) begin
      new_bit = wave_i.old_bit;
    end else if (p_i == CH_STAR) begin
      if (!q_valid_i) begin
        new_bit = 1'b0;
      end else if (q_hit) begin
        new_bit = bit_q | wave_i.new_bit2;
      end else begin
        new_bit = wave_i.new_bit2;
      end
    end else if (p_i == ctrl_i.text_byte) begin
      new_bit = wave_i.old_bit;
    end else begin
      new_bit = 1'b0;
    end
  end

  always_comb begin
    bit_d = bit_q;
    if (wave_i.token) begin
      bit_d = new_bit;
    end else if (ctrl_i.clear && !in_range_i) begin
      bit_d = 1'b0;
    end
  end

  always_comb begin
    wave_d.token    = wave_i.token && not_last_i;
    wave_d.old_bit  = bit_q;
    wave_d.new_bit  = new_bit;
    wave_d.new_bit2 = wave_i.new_bit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= 1'b0;
      wave_q <= '0;
    end else begin
      bit_q  <= bit_d;
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;
  assign bit_o  = bit_q;

endmodule

>>> hw/rtl/dspm_chain.sv
// row of match cells, one per pattern position
module dspm_chain
  import dspm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32,
  localparam int unsigned LW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic [PAT_BYTES*8-1:0]   pattern_i,
  input  logic [LW-1:0]            m_i,
  input  wave_t                    head_i,
  output logic [PATTERN_MAX:1]     row_o,
  output logic [PATTERN_MAX:0]     tokens_o
);

  wave_t wave [PATTERN_MAX+1];

  assign wave[0] = head_i;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    logic [7:0] p;
    logic [7:0] q;
    logic       q_valid;

    if (g < PAT_BYTES) begin : g_p
      assign p = pattern_i[8*g +: 8];
    end else begin : g_p_zero
      assign p = 8'h00;
    end

    if (g == 0) begin : g_q_none
      assign q       = 8'h00;
      assign q_valid = 1'b0;
    end else if (g - 1 < PAT_BYTES) begin : g_q
      assign q       = pattern_i[8*(g-1) +: 8];
      assign q_valid = 1'b1;
    end else begin : g_q_zero
      assign q       = 8'h00;
      assign q_valid = 1'b1;
    end

    dspm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .p_i        (p),
      .q_i        (q),
      .q_valid_i  (q_valid),
      .in_range_i (m_i >= LW'(g + 1)),
      .not_last_i (m_i > LW'(g + 1)),
      .wave_i     (wave[g]),
      .wave_o     (wave[g+1]),
      .bit_o      (row_o[g+1])
    );
  end

  for (genvar t = 0; t <= PATTERN_MAX; t++) begin : g_tok
    assign tokens_o[t] = wave[t].token;
  end

endmodule

>>> hw/rtl/dot_star_pattern_matcher.sv
// top level of the streaming dot-star pattern matcher
//
//  channel  | direction | handshake              | word
//  ---------+-----------+------------------------+----------------------------
//  in       | input     | in_valid_i / in_stall_o   | in_word_i (in_word_t)
//  out      | output    | out_valid_o / out_stall_i | out_word_o (out_word_t)
//  cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// a wave runs down the cell row one cell per cycle, across the first m cells,
// with m the effective pattern length
// a plain byte takes one pass, a start byte two passes, an empty-text item one
// pass; the word is taken in the idle state and the result loaded in the done state
// reset clears the row, the pattern registers and the length
// a finished result waits in the output register while the next word is taken
module dot_star_pattern_matcher
  import dspm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CW = (LW > LEN_W) ? LW : LEN_W;

  logic [NUM_WORDS-1:0][WORD_W-1:0] pat_q;
  logic [LEN_W-1:0]                 len_q;
  logic [LW-1:0]                    m;

  state_e            state_q, state_d;
  logic [LW-1:0]     cnt_q, cnt_d;
  logic              row0_q, row0_d;
  logic [7:0]        text_q;
  logic              empty_q;
  logic              last_q;
  logic              out_valid_q;
  out_word_t         out_word_q;

  logic              accept;
  logic              pass_last;
  logic              out_free;
  logic              go;
  logic              load_empty;
  logic              out_load;
  cell_ctrl_t        ctrl;
  wave_t             head;
  logic [PATTERN_MAX:1] row_cells;
  logic [PATTERN_MAX:0] row;
  logic [PATTERN_MAX:0] tokens;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      len_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PATTERN_WORD_0: pat_q[0] <= cfg_data_i;
        CFG_PATTERN_WORD_1: pat_q[1] <= cfg_data_i;
        CFG_PATTERN_WORD_2: pat_q[2] <= cfg_data_i;
        CFG_PATTERN_WORD_3: pat_q[3] <= cfg_data_i;
        CFG_PATTERN_LENGTH: len_q    <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective length, saturated to the cell count
  assign m = (CW'(len_q) > CW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(len_q);

  assign accept    = in_valid_i && !in_stall_o;
  assign pass_last = (LW'(1) + cnt_q >= m) || (m == '0);
  assign out_free  = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_word_i.empty_text || in_word_i.string_start) begin
            state_d = ST_EMPTY;
          end else begin
            state_d = ST_APPLY;
          end
        end
      end
      ST_EMPTY: begin
        if (pass_last) begin
          state_d = empty_q ? ST_DONE : ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (pass_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    go         = 1'b0;
    load_empty = 1'b0;
    out_load   = 1'b0;
    cnt_d      = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_EMPTY: begin
        go         = (cnt_q == '0);
        load_empty = 1'b1;
        cnt_d      = pass_last ? '0 : cnt_q + LW'(1);
      end
      ST_APPLY: begin
        go    = (cnt_q == '0);
        cnt_d = pass_last ? '0 : cnt_q + LW'(1);
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    row0_d = row0_q;
    if (go) begin
      row0_d = load_empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      row0_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row0_q  <= row0_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      text_q  <= in_word_i.text_byte;
      empty_q <= in_word_i.empty_text;
      last_q  <= in_word_i.last_byte;
    end
    if (out_load) begin
      out_word_q.whole_match <= row[m];
      out_word_q.end_of_text <= last_q;
    end
  end

  // cell row
  assign ctrl.clear      = go;
  assign ctrl.load_empty = load_empty;
  assign ctrl.text_byte  = text_q;

  assign head.token    = go;
  assign head.old_bit  = row0_q;
  assign head.new_bit  = load_empty;
  assign head.new_bit2 = 1'b0;

  dspm_chain #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .pattern_i (pat_q),
    .m_i       (m),
    .head_i    (head),
    .row_o     (row_cells),
    .tokens_o  (tokens)
  );

  assign row = {row_cells, row0_q};

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // checks
  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EMPTY || state_q == ST_APPLY))
    else $error("accepted word did not start a pass");

  a_single_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tokens))
    else $error("more than one wave in the cell row");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

  a_idle_no_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (tokens == '0))
    else $error("wave still running when the result is taken");

endmodule
